>>> rtl/core/key_binding_multimap_table_unit_defines.svh
// Assertion macros used by the key binding table unit.
`ifndef KEY_BINDING_MULTIMAP_TABLE_UNIT_DEFINES_SVH
`define KEY_BINDING_MULTIMAP_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KBMT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("kbmt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KBMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("kbmt assertion failed");

`endif

>>> rtl/core/kbmt_pkg.sv
`default_nettype none

package kbmt_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned KsW   = 32;
  localparam int unsigned ActW  = 8;
  localparam int unsigned StW   = 3;
  localparam int unsigned SlotW = 6;
  localparam int unsigned EntW  = KsW + ActW;

  typedef enum logic [OpW-1:0] {
    OP_STORE           = 2'd0,
    OP_REMOVE          = 2'd1,
    OP_LOOKUP_RESTART  = 2'd2,
    OP_LOOKUP_CONTINUE = 2'd3
  } op_e;

  typedef enum logic [StW-1:0] {
    STAT_DONE  = 3'd0,
    STAT_DUP   = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_MATCH = 3'd3,
    STAT_END   = 3'd4
  } status_e;

endpackage

`default_nettype wire

>>> rtl/core/kbmt_ram.sv
`default_nettype none

module kbmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/key_binding_multimap_table_unit.sv
// Channel  Handshake                 Payload
// input    in_valid_i / in_ready_o   op_i, keysym_i, action_i
// output   out_valid_o / out_ready_i found_action_o, status_o, slot_o
//
// An item scans the filled entries one by one through the entry RAM's single read port.
// Reset clears the fill count and the cursor; it does not clear the RAM itself.
// A new beat is taken whenever the scan sequencer is idle, even while a result
// waits in the output register; a stalled output holds the finished result.
`default_nettype none
`include "key_binding_multimap_table_unit_defines.svh"

module key_binding_multimap_table_unit
  import kbmt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [OpW-1:0]    op_i,
  input  wire logic [KsW-1:0]    keysym_i,
  input  wire logic [ActW-1:0]   action_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [ActW-1:0]   found_action_o,
  output logic      [StW-1:0]    status_o,
  output logic      [SlotW-1:0]  slot_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  op_e              op_q, op_d;
  logic [KsW-1:0]   ks_q, ks_d;
  logic [ActW-1:0]  act_q, act_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             rvalid_q, rvalid_d;
  logic [AW-1:0]    rd_idx_q, rd_idx_d;
  logic             free_found_q, free_found_d;
  logic [AW-1:0]    free_idx_q, free_idx_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    cursor_q, cursor_d;
  logic [ActW-1:0]  res_act_q, res_act_d;
  status_e          res_st_q, res_st_d;
  logic [SlotW-1:0] res_slot_q, res_slot_d;
  logic             out_valid_q, out_valid_d;
  logic [ActW-1:0]  found_q;
  status_e          status_q;
  logic [SlotW-1:0] slot_q;
  logic             out_load;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EntW-1:0]  ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [EntW-1:0]  ram_rdata;
  logic [KsW-1:0]   rd_ks;
  logic [ActW-1:0]  rd_act;
  logic             issue;
  op_e              in_op;

  kbmt_ram #(
    .WIDTH (EntW),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_act = ram_rdata[ActW-1:0];
  assign rd_ks  = ram_rdata[ActW +: KsW];
  assign in_op  = op_e'(op_i);
  assign issue  = (idx_q < fill_q);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    ks_d         = ks_q;
    act_d        = act_q;
    idx_d        = idx_q;
    rvalid_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    fill_d       = fill_q;
    cursor_d     = cursor_q;
    res_act_d    = res_act_q;
    res_st_d     = res_st_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = rd_idx_q;
    ram_wdata    = '0;
    ram_raddr    = idx_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = in_op;
          ks_d         = keysym_i;
          act_d        = action_i;
          free_found_d = 1'b0;
          res_act_d    = '0;
          res_slot_d   = '0;
          idx_d        = (in_op == OP_LOOKUP_CONTINUE) ? cursor_q : '0;
          if ((in_op == OP_STORE || in_op == OP_REMOVE) && action_i == '0) begin
            res_st_d = (in_op == OP_STORE) ? STAT_DUP : STAT_DONE;
            state_d  = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_d    = idx_q + CW'(1);
          rvalid_d = 1'b1;
          rd_idx_d = idx_q[AW-1:0];
        end
        if (rvalid_q) begin
          case (op_q)
            OP_STORE: begin
              if (rd_ks == ks_q && rd_act == act_q) begin
                res_st_d   = STAT_DUP;
                res_slot_d = SlotW'(rd_idx_q);
                rvalid_d   = 1'b0;
                state_d    = S_DONE;
              end else if (rd_act == '0 && !free_found_q) begin
                free_found_d = 1'b1;
                free_idx_d   = rd_idx_q;
              end
            end
            OP_REMOVE: begin
              if (rd_act == act_q) begin
                ram_we    = 1'b1;
                ram_waddr = rd_idx_q;
                ram_wdata = '0;
              end
            end
            default: begin
              if (rd_act != '0 && rd_ks == ks_q) begin
                res_act_d  = rd_act;
                res_st_d   = STAT_MATCH;
                res_slot_d = SlotW'(rd_idx_q);
                cursor_d   = CW'(rd_idx_q) + CW'(1);
                rvalid_d   = 1'b0;
                state_d    = S_DONE;
              end
            end
          endcase
        end else if (!issue) begin
          state_d = S_DONE;
          case (op_q)
            OP_STORE: begin
              if (free_found_q) begin
                ram_we     = 1'b1;
                ram_waddr  = free_idx_q;
                ram_wdata  = {ks_q, act_q};
                res_st_d   = STAT_DONE;
                res_slot_d = SlotW'(free_idx_q);
              end else if (fill_q >= DepthC) begin
                res_st_d = STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = fill_q[AW-1:0];
                ram_wdata  = {ks_q, act_q};
                fill_d     = fill_q + CW'(1);
                res_st_d   = STAT_DONE;
                res_slot_d = SlotW'(fill_q);
              end
            end
            OP_REMOVE: begin
              res_st_d = STAT_DONE;
            end
            default: begin
              cursor_d = fill_q;
              res_st_d = STAT_END;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rvalid_q     <= 1'b0;
      free_found_q <= 1'b0;
      fill_q       <= '0;
      cursor_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rvalid_q     <= rvalid_d;
      free_found_q <= free_found_d;
      fill_q       <= fill_d;
      cursor_q     <= cursor_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ks_q       <= ks_d;
    act_q      <= act_d;
    idx_q      <= idx_d;
    rd_idx_q   <= rd_idx_d;
    free_idx_q <= free_idx_d;
    res_act_q  <= res_act_d;
    res_st_q   <= res_st_d;
    res_slot_q <= res_slot_d;
    if (out_load) begin
      found_q  <= res_act_q;
      status_q <= res_st_q;
      slot_q   <= res_slot_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_action_o = found_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;

  // The cursor never runs past the filled part of the table.
  `KBMT_ASSERT_SAME(a_cursor_in_fill, clk_i, rst_ni, 1'b1, cursor_q <= fill_q)
  // The fill count stays within the table.
  `KBMT_ASSERT_SAME(a_fill_in_depth, clk_i, rst_ni, 1'b1, fill_q <= DepthC)
  // The fill count only ever grows by one entry at a time.
  `KBMT_ASSERT_NEXT(a_fill_step, clk_i, rst_ni, 1'b1,
                    fill_q == $past(fill_q) || fill_q == $past(fill_q) + CW'(1))
  // Entries are written only by the scan sequencer.
  `KBMT_ASSERT_SAME(a_write_in_scan, clk_i, rst_ni, ram_we, state_q == S_SCAN)
  // A matching lookup always reports a live action.
  `KBMT_ASSERT_SAME(a_match_has_action, clk_i, rst_ni,
                    out_valid_q && status_q == STAT_MATCH, found_q != '0)

endmodule

`default_nettype wire
